/* sv/lcdns_pkg.sv */
// ----------------------------------------------------------------------------
// lcdns_pkg
// Shared types, codes and the power-up sequence table of the character LCD
// nibble sequencer.
// ----------------------------------------------------------------------------
package lcdns_pkg;

  // Command codes
  localparam logic [2:0] ACT_INIT   = 3'd0;
  localparam logic [2:0] ACT_CLEAR  = 3'd1;
  localparam logic [2:0] ACT_CURSOR = 3'd2;
  localparam logic [2:0] ACT_SHOWC  = 3'd3;
  localparam logic [2:0] ACT_BLINK  = 3'd4;
  localparam logic [2:0] ACT_PRINT  = 3'd5;

  // Instruction bytes
  localparam logic [7:0] CMD_CLEAR       = 8'b0000_0001;
  localparam logic [7:0] CMD_DISP_ON     = 8'b0000_1100;
  localparam logic [7:0] CTRL_CURSOR_BIT = 8'b0000_0010;
  localparam logic [7:0] CTRL_BLINK_BIT  = 8'b0000_0001;

  // Delays in milliseconds
  localparam logic [6:0] WAIT_LONG  = 7'd100;
  localparam logic [6:0] WAIT_PRINT = 7'd2;
  localparam logic [6:0] WAIT_NONE  = 7'd0;

  // Step counts: init emits twelve nibbles, a byte two
  localparam int         INIT_STEPS = 12;
  localparam int         STEP_W     = $clog2(INIT_STEPS);
  localparam logic [STEP_W-1:0] INIT_LAST = STEP_W'(INIT_STEPS - 1);
  localparam logic [STEP_W-1:0] BYTE_LAST = STEP_W'(1);

  // Command queue depth
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Input command
  typedef struct packed {
    logic [2:0] action;
    logic [7:0] char_code;
    logic [5:0] column;
    logic       row;
    logic       enable_flag;
  } cmd_t;

  // Output nibble write
  typedef struct packed {
    logic [3:0] nibble;
    logic       data_select;
    logic [3:0] wait_before_ms;
    logic [6:0] wait_after_ms;
    logic       last;
  } nib_t;

  // Classified job passed from front to back
  typedef struct packed {
    logic       is_init;
    logic [7:0] byte_val;
    logic       data_select;
    logic [6:0] wait_after_ms;
  } job_t;

  // Power-up sequence: 3,3,3,2 then bytes 0x28, 0x0C, 0x01, 0x06
  function automatic nib_t init_nibble(input logic [STEP_W-1:0] idx);
    nib_t n;
    n = '0;
    unique case (idx)
      4'd0:  begin n.nibble = 4'h3; n.wait_before_ms = 4'd15; end
      4'd1:  begin n.nibble = 4'h3; n.wait_before_ms = 4'd5;  end
      4'd2:  begin n.nibble = 4'h3; n.wait_before_ms = 4'd1;  end
      4'd3:  begin n.nibble = 4'h2; n.wait_before_ms = 4'd1;  end
      4'd4:  n.nibble = 4'h2;
      4'd5:  n.nibble = 4'h8;
      4'd6:  begin n.nibble = 4'h0; n.wait_before_ms = 4'd1;  end
      4'd7:  n.nibble = 4'hC;
      4'd8:  begin n.nibble = 4'h0; n.wait_before_ms = 4'd1;  end
      4'd9:  n.nibble = 4'h1;
      4'd10: begin n.nibble = 4'h0; n.wait_before_ms = 4'd1;  end
      4'd11: begin n.nibble = 4'h6; n.last = 1'b1;            end
      default: n = '0;
    endcase
    return n;
  endfunction

endpackage

/* sv/lcdns_front.sv */
// ----------------------------------------------------------------------------
// lcdns_front
// Accepts commands, keeps the display-control byte and turns each known command
// into one job for the back end; unknown commands produce no job.
// ----------------------------------------------------------------------------
module lcdns_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_stall,
  input  lcdns_pkg::cmd_t cmd,
  input  logic            q_full,
  output logic            q_push,
  output lcdns_pkg::job_t q_job
);
  import lcdns_pkg::*;

  logic [7:0] display_control;
  logic [7:0] display_control_next;
  logic [7:0] ctrl_bit;
  logic       job_ok;
  logic       accept;

  assign cmd_stall = q_full;
  assign accept    = cmd_valid && !q_full;
  assign ctrl_bit  = (cmd.action == ACT_SHOWC) ? CTRL_CURSOR_BIT : CTRL_BLINK_BIT;

  // Classify the command
  always_comb begin
    display_control_next = display_control;
    job_ok               = 1'b1;
    q_job                = '0;
    unique case (cmd.action)
      ACT_INIT: begin
        q_job.is_init        = 1'b1;
        display_control_next = CMD_DISP_ON;
      end
      ACT_CLEAR: begin
        q_job.byte_val      = CMD_CLEAR;
        q_job.wait_after_ms = WAIT_LONG;
      end
      ACT_CURSOR: begin
        q_job.byte_val      = {1'b1, cmd.row, cmd.column};
        q_job.wait_after_ms = WAIT_LONG;
      end
      ACT_SHOWC, ACT_BLINK: begin
        display_control_next = cmd.enable_flag ? (display_control | ctrl_bit)
                                               : (display_control & ~ctrl_bit);
        q_job.byte_val       = display_control_next;
        q_job.wait_after_ms  = WAIT_NONE;
      end
      ACT_PRINT: begin
        q_job.byte_val      = cmd.char_code;
        q_job.data_select   = 1'b1;
        q_job.wait_after_ms = WAIT_PRINT;
      end
      default: job_ok = 1'b0;
    endcase
  end

  // Drop unknown commands, queue the rest
  assign q_push = accept && job_ok;

  // Hold the display-control byte
  always_ff @(posedge clk) begin
    if (rst) begin
      display_control <= '0;
    end else if (accept) begin
      display_control <= display_control_next;
    end
  end

endmodule

/* sv/lcdns_queue.sv */
// ----------------------------------------------------------------------------
// lcdns_queue
// Short job queue that decouples command intake from nibble output.
// ----------------------------------------------------------------------------
module lcdns_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lcdns_pkg::job_t push_job,
  input  logic            pop,
  output lcdns_pkg::job_t head,
  output logic            full,
  output logic            empty
);
  import lcdns_pkg::*;

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* sv/lcdns_back.sv */
// ----------------------------------------------------------------------------
// lcdns_back
// Walks the job at the head of the queue and emits one nibble write per
// cycle into the output register, unless the output stalls or the queue is empty.
// ----------------------------------------------------------------------------
module lcdns_back (
  input  logic            clk,
  input  logic            rst,
  input  lcdns_pkg::job_t head,
  input  logic            empty,
  output logic            pop,
  output logic            nib_valid,
  input  logic            nib_stall,
  output lcdns_pkg::nib_t nib
);
  import lcdns_pkg::*;

  logic [STEP_W-1:0] step;
  logic              emit;
  logic              final_step;
  nib_t              nib_next;

  assign emit       = !empty && (!nib_valid || !nib_stall);
  assign final_step = head.is_init ? (step == INIT_LAST) : (step == BYTE_LAST);
  assign pop        = emit && final_step;

  // Build the nibble for the current step, high nibble first
  always_comb begin
    nib_next = '0;
    if (head.is_init) begin
      nib_next = init_nibble(step);
    end else if (step == '0) begin
      nib_next.nibble      = head.byte_val[7:4];
      nib_next.data_select = head.data_select;
    end else begin
      nib_next.nibble        = head.byte_val[3:0];
      nib_next.data_select   = head.data_select;
      nib_next.wait_after_ms = head.wait_after_ms;
      nib_next.last          = 1'b1;
    end
  end

  // Advance the step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      step <= '0;
    end else if (emit) begin
      step <= final_step ? '0 : step + 1'b1;
    end
  end

  // Output register: load on transfer or when empty
  always_ff @(posedge clk) begin
    if (rst) begin
      nib_valid <= 1'b0;
    end else if (emit) begin
      nib_valid <= 1'b1;
    end else if (!nib_stall) begin
      nib_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      nib <= nib_next;
    end
  end

endmodule

/* sv/char_lcd_nibble_sequencer_core.sv */
// ----------------------------------------------------------------------------
// char_lcd_nibble_sequencer_core
// Character LCD command to 4-bit bus nibble sequencer.
// ----------------------------------------------------------------------------
// Takes one high-level LCD command per transfer and emits the nibble writes
// for a 4-bit HD44780-style bus, high nibble first, each tagged with register
// select, wait-before and wait-after delays and a last flag. Clear, set
// cursor, cursor/blink and print emit two nibbles; init emits twelve; actions
// 6 and 7 are accepted and dropped. The output port delivers one nibble per
// cycle while it is not stalled. A two-entry job queue sits between command
// intake and the nibble walker, so commands keep being accepted while earlier
// nibbles wait on a stalled output, until the queue fills. The cursor/blink
// state updates when the command is accepted.
// ----------------------------------------------------------------------------
module char_lcd_nibble_sequencer_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_stall,
  input  lcdns_pkg::cmd_t cmd,
  output logic            nib_valid,
  input  logic            nib_stall,
  output lcdns_pkg::nib_t nib
);
  import lcdns_pkg::*;

  job_t q_job;
  job_t q_head;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;

  lcdns_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_job)
  );

  lcdns_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (q_job),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  lcdns_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (q_head),
    .empty     (q_empty),
    .pop       (q_pop),
    .nib_valid (nib_valid),
    .nib_stall (nib_stall),
    .nib       (nib)
  );

endmodule

/* sim/tb_char_lcd_nibble_sequencer_core.sv */
// ----------------------------------------------------------------------------
// tb_char_lcd_nibble_sequencer_core
// Self-checking testbench for the character LCD nibble sequencer.
// ----------------------------------------------------------------------------
// Sends LCD commands (a directed opening, then weighted random traffic) in
// bursts with random gaps, while the nibble side stalls in changing
// patterns. A local model of the sequencer, including its cursor/blink
// byte, predicts every nibble write at command transfer. Each nibble
// transfer is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_char_lcd_nibble_sequencer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import lcdns_pkg::*;

  // Codes the block drops
  localparam logic [2:0] ACT_UNUSED_6 = 3'd6;
  localparam logic [2:0] ACT_UNUSED_7 = 3'd7;

  // Instruction bytes and nibbles not found in the package
  localparam logic [7:0] CMD_FUNC_4BIT  = 8'h28;
  localparam logic [7:0] CMD_ENTRY_MODE = 8'h06;
  localparam logic [7:0] CMD_SET_DDRAM  = 8'h80;
  localparam logic [3:0] NIB_WAKE       = 4'h3;
  localparam logic [3:0] NIB_4BIT       = 4'h2;

  // Register select and wait-before values
  localparam logic       RS_INSTR     = 1'b0;
  localparam logic       RS_DATA      = 1'b1;
  localparam logic [3:0] PRE_NONE     = 4'd0;
  localparam logic [3:0] PRE_SHORT    = 4'd1;
  localparam logic [3:0] PRE_WAKE2    = 4'd5;
  localparam logic [3:0] PRE_POWER_UP = 4'd15;

  localparam int RANDOM_CMDS = 250;
  localparam int DRAIN_CYCLES = 40;

  typedef enum logic [1:0] {RX_FREE, RX_COIN, RX_RUNS, RX_EVERY3} rx_mode_e;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_t cmd = '0;
  logic nib_valid;
  logic nib_stall = 1'b0;
  nib_t nib;

  cmd_t cmd_backlog[$];
  nib_t expected_writes[$];
  logic [7:0] lcd_ctrl = 8'h00;
  int mismatch_count = 0;

  int burst_left = 4;
  int gap_left = 0;

  rx_mode_e rx_mode = RX_FREE;
  int rx_phase_left = 0;
  int rx_run_left = 0;
  logic rx_run_stall = 1'b0;
  int rx_tick = 0;

  char_lcd_nibble_sequencer_core DUT (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .nib_valid(nib_valid),
    .nib_stall(nib_stall),
    .nib(nib)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predicted nibble writes
  function automatic void queue_write(logic [3:0] bits, logic rs, logic [3:0] pre_ms,
                                      logic [6:0] post_ms, logic fin);
    nib_t w;
    w.nibble = bits;
    w.data_select = rs;
    w.wait_before_ms = pre_ms;
    w.wait_after_ms = post_ms;
    w.last = fin;
    expected_writes.push_back(w);
  endfunction

  // High nibble first; only the high nibble carries the wait-before
  function automatic void queue_byte(logic [7:0] b, logic rs, logic [3:0] pre_ms,
                                     logic [6:0] post_ms, logic fin);
    queue_write(b[7:4], rs, pre_ms, WAIT_NONE, 1'b0);
    queue_write(b[3:0], rs, PRE_NONE, post_ms, fin);
  endfunction

  function automatic void predict_command(cmd_t c);
    logic [7:0] ctrl_bit;
    case (c.action)
      ACT_INIT: begin
        queue_write(NIB_WAKE, RS_INSTR, PRE_POWER_UP, WAIT_NONE, 1'b0);
        queue_write(NIB_WAKE, RS_INSTR, PRE_WAKE2, WAIT_NONE, 1'b0);
        queue_write(NIB_WAKE, RS_INSTR, PRE_SHORT, WAIT_NONE, 1'b0);
        queue_write(NIB_4BIT, RS_INSTR, PRE_SHORT, WAIT_NONE, 1'b0);
        queue_byte(CMD_FUNC_4BIT, RS_INSTR, PRE_NONE, WAIT_NONE, 1'b0);
        queue_byte(CMD_DISP_ON, RS_INSTR, PRE_SHORT, WAIT_NONE, 1'b0);
        queue_byte(CMD_CLEAR, RS_INSTR, PRE_SHORT, WAIT_NONE, 1'b0);
        queue_byte(CMD_ENTRY_MODE, RS_INSTR, PRE_SHORT, WAIT_NONE, 1'b1);
        lcd_ctrl = CMD_DISP_ON;
      end
      ACT_CLEAR: begin
        queue_byte(CMD_CLEAR, RS_INSTR, PRE_NONE, WAIT_LONG, 1'b1);
      end
      ACT_CURSOR: begin
        // column + 64*row never carries out of bit 6
        queue_byte(CMD_SET_DDRAM | 8'({c.row, c.column}), RS_INSTR, PRE_NONE, WAIT_LONG,
                   1'b1);
      end
      ACT_SHOWC, ACT_BLINK: begin
        ctrl_bit = (c.action == ACT_SHOWC) ? CTRL_CURSOR_BIT : CTRL_BLINK_BIT;
        lcd_ctrl = c.enable_flag ? (lcd_ctrl | ctrl_bit) : (lcd_ctrl & ~ctrl_bit);
        queue_byte(lcd_ctrl, RS_INSTR, PRE_NONE, WAIT_NONE, 1'b1);
      end
      ACT_PRINT: begin
        queue_byte(c.char_code, RS_DATA, PRE_NONE, WAIT_PRINT, 1'b1);
      end
      default: begin
        // unused codes produce nothing
      end
    endcase
  endfunction

  function automatic cmd_t make_cmd(logic [2:0] act, logic [7:0] ch, logic [5:0] col,
                                    logic r, logic en);
    cmd_t c;
    c.action = act;
    c.char_code = ch;
    c.column = col;
    c.row = r;
    c.enable_flag = en;
    return c;
  endfunction

  // Mostly valid commands, weighted toward print; a few dropped codes
  function automatic cmd_t random_cmd();
    cmd_t c;
    int pick;
    c.char_code = 8'($urandom);
    c.column = 6'($urandom);
    c.row = 1'($urandom);
    c.enable_flag = 1'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 5) c.action = ACT_INIT;
    else if (pick < 12) c.action = ACT_CLEAR;
    else if (pick < 28) c.action = ACT_CURSOR;
    else if (pick < 42) c.action = ACT_SHOWC;
    else if (pick < 56) c.action = ACT_BLINK;
    else if (pick < 95) c.action = ACT_PRINT;
    else c.action = pick[0] ? ACT_UNUSED_6 : ACT_UNUSED_7;
    return c;
  endfunction

  // Command driver: bursts of transfers separated by idle gaps
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!cmd_valid || !cmd_stall) begin
      if (gap_left != 0 || cmd_backlog.size() == 0) begin
        if (gap_left != 0) gap_left--;
        cmd_valid <= 1'b0;
      end else begin
        cmd <= cmd_backlog.pop_front();
        cmd_valid <= 1'b1;
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // Nibble-side stall: switch between randomly chosen patterns
  always @(posedge clk) begin
    if (rx_phase_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_phase_left = $urandom_range(20, 80);
    end else begin
      rx_phase_left--;
    end
    rx_tick++;
    case (rx_mode)
      RX_FREE: nib_stall <= 1'b0;
      RX_COIN: nib_stall <= ($urandom_range(0, 1) == 1);
      RX_RUNS: begin
        if (rx_run_left == 0) begin
          rx_run_left = $urandom_range(1, 12);
          rx_run_stall = !rx_run_stall;
        end
        rx_run_left--;
        nib_stall <= rx_run_stall;
      end
      default: nib_stall <= (rx_tick % 3 == 0);
    endcase
  end

  // Monitor: predict on command transfer, then check nibble transfer
  always @(posedge clk) begin
    nib_t want;
    if (rst) begin
      lcd_ctrl = 8'h00;
    end else begin
      if (cmd_valid && !cmd_stall) predict_command(cmd);
      if (nib_valid && !nib_stall) begin
        if (expected_writes.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t: unexpected nibble write %p", $realtime, nib);
        end else begin
          want = expected_writes.pop_front();
          if (nib.nibble !== want.nibble || nib.data_select !== want.data_select ||
              nib.wait_before_ms !== want.wait_before_ms ||
              nib.wait_after_ms !== want.wait_after_ms || nib.last !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t: nibble write mismatch: expected %p, got %p",
                       $realtime, want, nib);
          end
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    cmd_t c;
    int counted;
    // cursor and blink before init act on the reset byte
    cmd_backlog.push_back(make_cmd(ACT_SHOWC, 8'h00, 6'd0, 1'b0, 1'b1));
    cmd_backlog.push_back(make_cmd(ACT_BLINK, 8'hFF, 6'd63, 1'b1, 1'b1));
    cmd_backlog.push_back(make_cmd(ACT_SHOWC, 8'h00, 6'd0, 1'b0, 1'b0));
    cmd_backlog.push_back(make_cmd(ACT_UNUSED_6, 8'hFF, 6'd63, 1'b1, 1'b1));
    cmd_backlog.push_back(make_cmd(ACT_UNUSED_7, 8'h00, 6'd0, 1'b0, 1'b0));
    cmd_backlog.push_back(make_cmd(ACT_INIT, 8'h00, 6'd0, 1'b0, 1'b0));
    cmd_backlog.push_back(make_cmd(ACT_CLEAR, 8'hFF, 6'd63, 1'b1, 1'b1));
    cmd_backlog.push_back(make_cmd(ACT_CURSOR, 8'h00, 6'd0, 1'b0, 1'b0));
    cmd_backlog.push_back(make_cmd(ACT_CURSOR, 8'h00, 6'd63, 1'b1, 1'b0));
    cmd_backlog.push_back(make_cmd(ACT_CURSOR, 8'h00, 6'd63, 1'b0, 1'b0));
    cmd_backlog.push_back(make_cmd(ACT_CURSOR, 8'h00, 6'd0, 1'b1, 1'b0));
    cmd_backlog.push_back(make_cmd(ACT_PRINT, 8'h00, 6'd0, 1'b0, 1'b0));
    cmd_backlog.push_back(make_cmd(ACT_PRINT, 8'hFF, 6'd63, 1'b1, 1'b1));
    cmd_backlog.push_back(make_cmd(ACT_PRINT, 8'hA5, 6'd21, 1'b0, 1'b1));
    cmd_backlog.push_back(make_cmd(ACT_SHOWC, 8'h00, 6'd0, 1'b0, 1'b1));
    cmd_backlog.push_back(make_cmd(ACT_BLINK, 8'h00, 6'd0, 1'b0, 1'b1));
    cmd_backlog.push_back(make_cmd(ACT_SHOWC, 8'h00, 6'd0, 1'b0, 1'b1));
    cmd_backlog.push_back(make_cmd(ACT_BLINK, 8'h00, 6'd0, 1'b0, 1'b0));
    cmd_backlog.push_back(make_cmd(ACT_BLINK, 8'h00, 6'd0, 1'b0, 1'b1));
    // init again restores the control byte over set bits
    cmd_backlog.push_back(make_cmd(ACT_INIT, 8'hFF, 6'd63, 1'b1, 1'b1));
    cmd_backlog.push_back(make_cmd(ACT_SHOWC, 8'h00, 6'd0, 1'b0, 1'b0));

    counted = 0;
    while (counted < RANDOM_CMDS) begin
      c = random_cmd();
      cmd_backlog.push_back(c);
      if (c.action != ACT_UNUSED_6 && c.action != ACT_UNUSED_7) counted++;
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // wait for every command, then every nibble, then watch for strays
    while (cmd_backlog.size() != 0 || cmd_valid) @(posedge clk);
    while (expected_writes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("PASS char_lcd_nibble_sequencer_core");
    end else begin
      $display("FAIL char_lcd_nibble_sequencer_core");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2ms;
    $display("FAIL char_lcd_nibble_sequencer_core");
    $finish;
  end

endmodule
